// File: design/dpes_pkg.sv
// ----------------------------------------------------------------------------
// dpes_pkg
// Shared types, codes and generator constants for the edge switcher.
// ----------------------------------------------------------------------------
package dpes_pkg;

  localparam int NODE_W  = 8;
  localparam int IDXP_W  = 10;
  localparam int TOTAL_W = 11;
  localparam int OP_W    = 2;
  localparam int OUT_W   = 3;
  localparam int SEED_W  = 64;
  localparam int PADDR_W = 4;

  localparam logic [63:0] PCG_MULT   = 64'd6364136223846793005;
  localparam logic [63:0] STREAM_XOR = 64'h0000_0000_CAFE_BABE;
  localparam int          XS_SHIFT1  = 18;
  localparam int          XS_SHIFT2  = 27;
  localparam int          ROT_SHIFT  = 59;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_SWAP  = 2'd1,
    OP_READ  = 2'd2,
    OP_START = 2'd3
  } op_t;

  typedef enum logic [OUT_W-1:0] {
    RES_DONE     = 3'd0,
    RES_SAME     = 3'd1,
    RES_LOOP     = 3'd2,
    RES_PARALLEL = 3'd3,
    RES_SWAPPED  = 3'd4,
    RES_ERROR    = 3'd5
  } outcome_t;

  // XSH-RR output of the generator, taken from the state before advance.
  function automatic logic [31:0] pcg_out(input logic [63:0] old);
    logic [31:0] xs;
    logic [4:0]  rot;
    logic [63:0] dbl;
    xs  = 32'(((old >> XS_SHIFT1) ^ old) >> XS_SHIFT2);
    rot = 5'(old >> ROT_SHIFT);
    dbl = {xs, xs} >> rot;
    return dbl[31:0];
  endfunction

endpackage

// File: design/degree_preserving_edge_switcher.sv
// ----------------------------------------------------------------------------
// degree_preserving_edge_switcher
// Edge table, adjacency bit matrix and PCG32 draw unit for degree-preserving
// edge swaps, driven by a one-hot sequencer around two synchronous memories.
// ----------------------------------------------------------------------------
// Swap steps from accepting edge to out_valid: two draws, two table reads, two
//   tests, eight row RMWs.
// Throughput: one word at a time; the next word is taken once the sequencer
//   is back in idle, while the previous result may still wait at the output.
// Reset: synchronous, active low. After reset all MAX_NODES*ROW_WORDS words of
//   the adjacency memory are swept to zero before the first word is taken.
module degree_preserving_edge_switcher #(
  parameter int MAX_NODES = 256,
  parameter int MAX_EDGES = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dpes_pkg::OP_W-1:0]       in_opcode,
  input  logic [dpes_pkg::NODE_W-1:0]     in_node_first,
  input  logic [dpes_pkg::NODE_W-1:0]     in_node_second,
  input  logic [dpes_pkg::IDXP_W-1:0]     in_edge_index,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dpes_pkg::OUT_W-1:0]      out_outcome,
  output logic [dpes_pkg::IDXP_W-1:0]     out_first_pick,
  output logic [dpes_pkg::IDXP_W-1:0]     out_second_pick,
  output logic [dpes_pkg::NODE_W-1:0]     out_end_first,
  output logic [dpes_pkg::NODE_W-1:0]     out_end_second,
  output logic [dpes_pkg::TOTAL_W-1:0]    out_edge_total,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dpes_pkg::PADDR_W-1:0]    paddr,
  input  logic [dpes_pkg::SEED_W-1:0]     pwdata,
  output logic [dpes_pkg::SEED_W-1:0]     prdata,
  output logic                            pready
);
  import dpes_pkg::*;

  // Geometry: each node owns ROW_WORDS 64-bit words of the adjacency matrix.
  localparam int ROW_WORDS = (MAX_NODES + 63) / 64;
  localparam int ADJ_DEPTH = MAX_NODES * ROW_WORDS;
  localparam int ADJ_AW    = $clog2(ADJ_DEPTH);
  localparam int IDX_W     = $clog2(MAX_EDGES);
  localparam int CNT_W     = $clog2(MAX_EDGES + 1);
  localparam int BP_W      = 32 + CNT_W;
  localparam int EDGE_DW   = 2 * NODE_W;

  typedef enum logic [14:0] {
    S_CLR  = 15'b000000000000001,
    S_IDLE = 15'b000000000000010,
    S_MUL0 = 15'b000000000000100,
    S_MUL1 = 15'b000000000001000,
    S_MUL2 = 15'b000000000010000,
    S_BND  = 15'b000000000100000,
    S_ERD2 = 15'b000000001000000,
    S_ECAP = 15'b000000010000000,
    S_TRD  = 15'b000000100000000,
    S_TCHK = 15'b000001000000000,
    S_RRD  = 15'b000010000000000,
    S_RWR  = 15'b000100000000000,
    S_EWR2 = 15'b001000000000000,
    S_RDAT = 15'b010000000000000,
    S_FIN  = 15'b100000000000000
  } state_t;

  // Adjacency word address of bit (u,v).
  function automatic logic [ADJ_AW-1:0] adj_addr(input logic [NODE_W-1:0] u,
                                                 input logic [NODE_W-1:0] v);
    return ADJ_AW'(32'(u) * ROW_WORDS + 32'(v >> 6));
  endfunction

  // ---------------- memories ----------------
  logic [63:0]        adj_mem [ADJ_DEPTH];
  logic [EDGE_DW-1:0] edge_mem [MAX_EDGES];

  logic               adj_we;
  logic [ADJ_AW-1:0]  adj_wa, adj_ra;
  logic [63:0]        adj_wd, adj_rd_r;
  logic               edge_we;
  logic [IDX_W-1:0]   edge_wa, edge_ra;
  logic [EDGE_DW-1:0] edge_wd, edge_rd_r;

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_wa] <= adj_wd;
    end
    adj_rd_r <= adj_mem[adj_ra];
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_wa] <= edge_wd;
    end
    edge_rd_r <= edge_mem[edge_ra];
  end

  // ---------------- registers ----------------
  state_t             st_r, st_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [63:0]        gst_r, gst_nxt;
  logic [63:0]        inc_r, inc_nxt;
  logic [63:0]        seed_r, seed_nxt;
  logic [ADJ_AW-1:0]  clr_r, clr_nxt;
  logic               seeding_r, seeding_nxt;
  logic               draw_r, draw_nxt;
  logic               tst_r, tst_nxt;
  logic [2:0]         k_r, k_nxt;
  logic               out_valid_r, out_valid_nxt;

  op_t                op_r, op_nxt;
  logic [NODE_W-1:0]  a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic [NODE_W-1:0]  e1_r, e1_nxt, e2_r, e2_nxt;
  logic [IDX_W-1:0]   p1_r, p1_nxt, p2_r, p2_nxt;
  logic [31:0]        rnd_r, rnd_nxt;
  logic [63:0]        acc_r, acc_nxt;
  outcome_t           res_r, res_nxt;

  logic [OUT_W-1:0]   o_outcome_r, o_outcome_nxt;
  logic [IDX_W-1:0]   o_p1_r, o_p1_nxt, o_p2_r, o_p2_nxt;
  logic [NODE_W-1:0]  o_e1_r, o_e1_nxt, o_e2_r, o_e2_nxt;
  logic [CNT_W-1:0]   o_cnt_r, o_cnt_nxt;

  // ---------------- arithmetic ----------------
  // One shared 32x32 multiplier steps the 64-bit LCG across S_MUL0, S_MUL1 and S_MUL2.
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;
  assign mul_p = 64'(mul_x) * 64'(mul_y);

  // Lemire bound: high word of draw times edge count.
  logic [BP_W-1:0]  bnd_p;
  logic [IDX_W-1:0] pick;
  assign bnd_p = BP_W'(rnd_r) * BP_W'(cnt_r);
  assign pick  = bnd_p[32 +: IDX_W];

  logic [63:0] inc_new;
  assign inc_new = ((seed_r ^ STREAM_XOR) << 1) | 64'd1;

  // Rewire list: clear (a,b),(b,a),(c,d),(d,c), then set (a,d),(d,a),(c,b),(b,c).
  logic [NODE_W-1:0] k_u, k_v;
  always_comb begin
    case (k_r)
      3'd0:    begin k_u = a_r; k_v = b_r; end
      3'd1:    begin k_u = b_r; k_v = a_r; end
      3'd2:    begin k_u = c_r; k_v = d_r; end
      3'd3:    begin k_u = d_r; k_v = c_r; end
      3'd4:    begin k_u = a_r; k_v = d_r; end
      3'd5:    begin k_u = d_r; k_v = a_r; end
      3'd6:    begin k_u = c_r; k_v = b_r; end
      default: begin k_u = b_r; k_v = c_r; end
    endcase
  end

  logic [63:0] k_bit;
  assign k_bit = 64'd1 << k_v[5:0];

  logic out_free;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (st_r == S_IDLE);

  // ---------------- sequencer ----------------
  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    gst_nxt       = gst_r;
    inc_nxt       = inc_r;
    seed_nxt      = seed_r;
    clr_nxt       = clr_r;
    seeding_nxt   = seeding_r;
    draw_nxt      = draw_r;
    tst_nxt       = tst_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r;
    e1_nxt = e1_r; e2_nxt = e2_r;
    p1_nxt = p1_r; p2_nxt = p2_r;
    rnd_nxt       = rnd_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    o_outcome_nxt = o_outcome_r;
    o_p1_nxt = o_p1_r; o_p2_nxt = o_p2_r;
    o_e1_nxt = o_e1_r; o_e2_nxt = o_e2_r;
    o_cnt_nxt     = o_cnt_r;
    mul_x         = gst_r[31:0];
    mul_y         = PCG_MULT[31:0];
    adj_we        = 1'b0;
    adj_wa        = clr_r;
    adj_wd        = '0;
    adj_ra        = adj_addr(k_u, k_v);
    edge_we       = 1'b0;
    edge_wa       = p1_r;
    edge_wd       = {a_r, d_r};
    edge_ra       = p1_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Seed register; reads return it at its slot.
    if (psel && penable && pwrite && !paddr[PADDR_W-1]) begin
      seed_nxt = pwdata;
    end

    unique case (st_r)
      S_CLR: begin
        adj_we = 1'b1;
        if (clr_r == ADJ_AW'(ADJ_DEPTH - 1)) begin
          if (seeding_r) begin
            inc_nxt = inc_new;
            gst_nxt = inc_new + seed_r;
            st_nxt  = S_MUL0;
          end else begin
            st_nxt  = S_IDLE;
          end
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = op_t'(in_opcode);
          a_nxt       = in_node_first;
          d_nxt       = in_node_second;
          p1_nxt      = '0;
          p2_nxt      = '0;
          e1_nxt      = '0;
          e2_nxt      = '0;
          seeding_nxt = 1'b0;
          res_nxt     = RES_DONE;
          unique case (op_t'(in_opcode))
            OP_LOAD: begin
              if (32'(cnt_r) >= MAX_EDGES || 32'(in_node_first) >= MAX_NODES ||
                  32'(in_node_second) >= MAX_NODES ||
                  in_node_first == in_node_second) begin
                res_nxt = RES_ERROR;
                st_nxt  = S_FIN;
              end else begin
                tst_nxt = 1'b0;
                st_nxt  = S_TRD;
              end
            end
            OP_SWAP: begin
              draw_nxt = 1'b0;
              rnd_nxt  = pcg_out(gst_r);
              st_nxt   = S_MUL0;
            end
            OP_READ: begin
              if (32'(in_edge_index) >= 32'(cnt_r)) begin
                res_nxt = RES_ERROR;
                st_nxt  = S_FIN;
              end else begin
                edge_ra = IDX_W'(in_edge_index);
                st_nxt  = S_RDAT;
              end
            end
            default: begin
              cnt_nxt     = '0;
              clr_nxt     = '0;
              seeding_nxt = 1'b1;
              st_nxt      = S_CLR;
            end
          endcase
        end
      end

      // state * M + inc, one 32-bit partial product a cycle
      S_MUL0: begin
        acc_nxt = mul_p + inc_r;
        st_nxt  = S_MUL1;
      end
      S_MUL1: begin
        mul_y   = PCG_MULT[63:32];
        acc_nxt = acc_r + {mul_p[31:0], 32'd0};
        st_nxt  = S_MUL2;
      end
      S_MUL2: begin
        mul_x   = gst_r[63:32];
        gst_nxt = acc_r + {mul_p[31:0], 32'd0};
        st_nxt  = seeding_r ? S_FIN : S_BND;
      end

      S_BND: begin
        if (!draw_r) begin
          p1_nxt   = pick;
          draw_nxt = 1'b1;
          rnd_nxt  = pcg_out(gst_r);
          st_nxt   = S_MUL0;
        end else begin
          p2_nxt = pick;
          if (pick == p1_r) begin
            res_nxt = RES_SAME;
            st_nxt  = S_FIN;
          end else begin
            edge_ra = p1_r;
            st_nxt  = S_ERD2;
          end
        end
      end

      S_ERD2: begin
        edge_ra = p2_r;
        a_nxt   = edge_rd_r[EDGE_DW-1:NODE_W];
        b_nxt   = edge_rd_r[NODE_W-1:0];
        st_nxt  = S_ECAP;
      end

      S_ECAP: begin
        c_nxt = edge_rd_r[EDGE_DW-1:NODE_W];
        d_nxt = edge_rd_r[NODE_W-1:0];
        if (a_r == edge_rd_r[NODE_W-1:0] || edge_rd_r[EDGE_DW-1:NODE_W] == b_r) begin
          res_nxt = RES_LOOP;
          st_nxt  = S_FIN;
        end else begin
          tst_nxt = 1'b0;
          st_nxt  = S_TRD;
        end
      end

      S_TRD: begin
        adj_ra = tst_r ? adj_addr(c_r, b_r) : adj_addr(a_r, d_r);
        st_nxt = S_TCHK;
      end

      S_TCHK: begin
        if (adj_rd_r[tst_r ? b_r[5:0] : d_r[5:0]]) begin
          res_nxt = (op_r == OP_LOAD) ? RES_ERROR : RES_PARALLEL;
          st_nxt  = S_FIN;
        end else if (op_r == OP_SWAP && !tst_r) begin
          tst_nxt = 1'b1;
          st_nxt  = S_TRD;
        end else if (op_r == OP_LOAD) begin
          edge_we = 1'b1;
          edge_wa = IDX_W'(cnt_r);
          cnt_nxt = cnt_r + 1'b1;
          k_nxt   = 3'd4;
          st_nxt  = S_RRD;
        end else begin
          k_nxt   = 3'd0;
          st_nxt  = S_RRD;
        end
      end

      S_RRD: begin
        st_nxt = S_RWR;
      end

      S_RWR: begin
        adj_we = 1'b1;
        adj_wa = adj_addr(k_u, k_v);
        adj_wd = k_r[2] ? (adj_rd_r | k_bit) : (adj_rd_r & ~k_bit);
        if (op_r == OP_LOAD && k_r == 3'd5) begin
          st_nxt = S_FIN;
        end else if (k_r == 3'd7) begin
          edge_we = 1'b1;
          st_nxt  = S_EWR2;
        end else begin
          k_nxt  = k_r + 1'b1;
          st_nxt = S_RRD;
        end
      end

      S_EWR2: begin
        edge_we = 1'b1;
        edge_wa = p2_r;
        edge_wd = {c_r, b_r};
        res_nxt = RES_SWAPPED;
        st_nxt  = S_FIN;
      end

      S_RDAT: begin
        e1_nxt = edge_rd_r[EDGE_DW-1:NODE_W];
        e2_nxt = edge_rd_r[NODE_W-1:0];
        st_nxt = S_FIN;
      end

      S_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_outcome_nxt = res_r;
          o_p1_nxt      = p1_r;
          o_p2_nxt      = p2_r;
          o_e1_nxt      = e1_r;
          o_e2_nxt      = e2_r;
          o_cnt_nxt     = cnt_r;
          st_nxt        = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      cnt_r       <= '0;
      gst_r       <= '0;
      inc_r       <= '0;
      seed_r      <= '0;
      clr_r       <= '0;
      seeding_r   <= 1'b0;
      draw_r      <= 1'b0;
      tst_r       <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      gst_r       <= gst_nxt;
      inc_r       <= inc_nxt;
      seed_r      <= seed_nxt;
      clr_r       <= clr_nxt;
      seeding_r   <= seeding_nxt;
      draw_r      <= draw_nxt;
      tst_r       <= tst_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    c_r         <= c_nxt;
    d_r         <= d_nxt;
    e1_r        <= e1_nxt;
    e2_r        <= e2_nxt;
    p1_r        <= p1_nxt;
    p2_r        <= p2_nxt;
    rnd_r       <= rnd_nxt;
    acc_r       <= acc_nxt;
    res_r       <= res_nxt;
    o_outcome_r <= o_outcome_nxt;
    o_p1_r      <= o_p1_nxt;
    o_p2_r      <= o_p2_nxt;
    o_e1_r      <= o_e1_nxt;
    o_e2_r      <= o_e2_nxt;
    o_cnt_r     <= o_cnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_outcome     = o_outcome_r;
  assign out_first_pick  = IDXP_W'(o_p1_r);
  assign out_second_pick = IDXP_W'(o_p2_r);
  assign out_end_first   = o_e1_r;
  assign out_end_second  = o_e2_r;
  assign out_edge_total  = TOTAL_W'(o_cnt_r);

  assign pready = 1'b1;
  assign prdata = paddr[PADDR_W-1] ? '0 : seed_r;

endmodule
